@@ rtl/egb_pkg.sv @@
// Shared widths, controller/datapath command and status types for the
// extended GCD core. No dependencies.
`default_nettype none
package egb_pkg;

	localparam int DATA_WIDTH = 32;               // coefficient width
	localparam int OPND_W     = DATA_WIDTH - 1;   // operand / remainder width
	localparam int CNT_W      = $clog2(OPND_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPND_W - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_DIV   = 4'b0100,
		S_UPD   = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;      // take new operands
		logic div_init;  // start a quotient/remainder pass
		logic div_step;  // one quotient bit
		logic update;    // rotate remainders and coefficients
		logic emit;      // write result register
	} cmd_t;

	typedef struct packed {
		logic r_new_zero;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/egb_datapath.sv @@
// Datapath of the extended GCD core: remainder and coefficient registers,
// bit-serial restoring divider with shift-add products, result register.
// Depends on egb_pkg.
`default_nettype none
module egb_datapath (
	input  wire logic                                 clk,
	input  wire egb_pkg::cmd_t                        cmd,
	output egb_pkg::sts_t                             sts,
	input  wire logic [egb_pkg::OPND_W-1:0]           a_value,
	input  wire logic [egb_pkg::OPND_W-1:0]           b_value,
	output logic [egb_pkg::OPND_W-1:0]                gcd_value,
	output logic signed [egb_pkg::DATA_WIDTH-1:0]     coeff_a,
	output logic signed [egb_pkg::DATA_WIDTH-1:0]     coeff_b
);

	localparam int W  = egb_pkg::OPND_W;
	localparam int DW = egb_pkg::DATA_WIDTH;

	logic [W-1:0]  r_old_q, r_new_q, rem_q, quo_q;
	logic [DW-1:0] x_old_q, x_new_q, y_old_q, y_new_q, px_q, py_q;
	logic          swapped_q;

	logic [W+1:0]  diff;
	logic          qbit;
	logic [W-1:0]  rem_next;

	// trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		diff     = {1'b0, rem_q, quo_q[W-1]} - {2'b00, r_new_q};
		qbit     = ~diff[W+1];
		rem_next = qbit ? diff[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
	end

	assign sts.r_new_zero = (r_new_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			swapped_q <= (a_value < b_value);
			r_old_q   <= (a_value < b_value) ? b_value : a_value;
			r_new_q   <= (a_value < b_value) ? a_value : b_value;
			x_old_q   <= DW'(1);
			x_new_q   <= '0;
			y_old_q   <= '0;
			y_new_q   <= DW'(1);
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= r_old_q;
			px_q  <= '0;
			py_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[W-2:0], qbit};
			// quotient bits arrive MSB first, so the products build by shift-add
			px_q  <= {px_q[DW-2:0], 1'b0} + (qbit ? x_new_q : '0);
			py_q  <= {py_q[DW-2:0], 1'b0} + (qbit ? y_new_q : '0);
		end
		if (cmd.update) begin
			r_old_q <= r_new_q;
			r_new_q <= rem_q;
			x_old_q <= x_new_q;
			x_new_q <= x_old_q - px_q;
			y_old_q <= y_new_q;
			y_new_q <= y_old_q - py_q;
		end
		if (cmd.emit) begin
			gcd_value <= r_old_q;
			coeff_a   <= swapped_q ? y_old_q : x_old_q;
			coeff_b   <= swapped_q ? x_old_q : y_old_q;
		end
	end

endmodule
`default_nettype wire

@@ rtl/egb_ctrl.sv @@
// Controller of the extended GCD core: sequences check, divide and update
// steps and owns the handshake flags. Depends on egb_pkg.
`default_nettype none
module egb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire egb_pkg::sts_t sts,
	output egb_pkg::cmd_t      cmd
);

	egb_pkg::state_t               state_q, state_d;
	logic [egb_pkg::CNT_W-1:0]     cnt_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == egb_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			egb_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = egb_pkg::S_CHECK;
				end
			end
			egb_pkg::S_CHECK: begin
				if (!sts.r_new_zero) begin
					cmd.div_init = 1'b1;
					state_d      = egb_pkg::S_DIV;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = egb_pkg::S_IDLE;
				end
			end
			egb_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == egb_pkg::CNT_LAST) state_d = egb_pkg::S_UPD;
			end
			egb_pkg::S_UPD: begin
				cmd.update = 1'b1;
				state_d    = egb_pkg::S_CHECK;
			end
			default: state_d = egb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egb_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == egb_pkg::S_DIV) cnt_q <= cnt_q + 1'b1;
			else                           cnt_q <= '0;
			if (cmd.emit)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/extended_gcd_bezout_core.sv @@
// Extended GCD core: returns gcd(a, b) with Bezout coefficients x, y such
// that gcd = x*a + y*b. One operand pair is worked on at a time. Each
// quotient/remainder step (at most about 46 of them for 31-bit operands)
// runs through the bit-serial restoring divider, which yields one quotient
// bit per cycle while the coefficient products build up alongside it by
// shift-add. The result sits in an output register, so the next beat is
// accepted while it waits to be taken. Depends on egb_pkg, egb_ctrl and
// egb_datapath.
`default_nettype none
module extended_gcd_bezout_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [egb_pkg::OPND_W-1:0]           a_value,
	input  wire logic [egb_pkg::OPND_W-1:0]           b_value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [egb_pkg::OPND_W-1:0]                gcd_value,
	output logic signed [egb_pkg::DATA_WIDTH-1:0]     coeff_a,
	output logic signed [egb_pkg::DATA_WIDTH-1:0]     coeff_b
);

	egb_pkg::cmd_t cmd;
	egb_pkg::sts_t sts;

	egb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	egb_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.a_value   (a_value),
		.b_value   (b_value),
		.gcd_value (gcd_value),
		.coeff_a   (coeff_a),
		.coeff_b   (coeff_b)
	);

endmodule
`default_nettype wire

@@ rtl/egb_checker.sv @@
// Port-level checks for the extended GCD core, bound to the top level.
// Depends on egb_pkg for widths.
`default_nettype none
module egb_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic [egb_pkg::OPND_W-1:0]           gcd_value,
	input  wire logic signed [egb_pkg::DATA_WIDTH-1:0] coeff_a,
	input  wire logic signed [egb_pkg::DATA_WIDTH-1:0] coeff_b
);

	// a waiting result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gcd_value)
			&& $stable(coeff_a) && $stable(coeff_b))
		else $error("result beat changed while stalled");

	// one item at a time: busy right after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after a beat");

	// no result can appear the cycle after an input is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// a fresh result frees the input side at once
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input not ready when result issued");

endmodule

bind extended_gcd_bezout_core egb_checker u_chk (.*);
`default_nettype wire

@@ tb/extended_gcd_bezout_core_test.sv @@
// Self-checking testbench for extended_gcd_bezout_core: gcd and Bezout coefficients
// of operand pairs, predicted in-bench and compared beat by beat.
// Depends on egb_pkg and the extended_gcd_bezout_core RTL.
`timescale 1ns / 100ps
module extended_gcd_bezout_core_test;

	localparam int OW = egb_pkg::OPND_W;
	localparam int CW = egb_pkg::DATA_WIDTH;
	localparam logic [OW-1:0] OPND_MAX = {OW{1'b1}};
	localparam int RANDOM_PER_PHASE = 125;

	typedef struct packed {
		logic [OW-1:0] gcd;
		logic [CW-1:0] ca;
		logic [CW-1:0] cb;
	} bezout_t;

	typedef struct packed {
		logic [OW-1:0] a;
		logic [OW-1:0] b;
		logic          typed;   // expected result written out below
		bezout_t       res;
	} stim_row_t;

	localparam int N_ROWS = 16;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{31'd0, 31'd0, 1'b1, '{31'd0, 32'd1, 32'd0}},             // both zero
		'{31'd5, 31'd0, 1'b1, '{31'd5, 32'd1, 32'd0}},             // b zero
		'{31'd0, 31'd7, 1'b1, '{31'd7, 32'd0, 32'd1}},             // a zero, swapped
		'{31'd1, 31'd1, 1'b1, '{31'd1, 32'd0, 32'd1}},             // equal, smallest
		'{OPND_MAX, OPND_MAX, 1'b1, '{OPND_MAX, 32'd0, 32'd1}},    // equal, largest
		'{OPND_MAX, 31'd1, 1'b1, '{31'd1, 32'd0, 32'd1}},
		'{31'd1, OPND_MAX, 1'b1, '{31'd1, 32'd1, 32'd0}},
		'{31'd12345, 31'd12345, 1'b1, '{31'd12345, 32'd0, 32'd1}},
		'{31'h4000_0000, 31'h2000_0000, 1'b1, '{31'h2000_0000, 32'd0, 32'd1}},
		'{31'd1836311903, 31'd1134903170, 1'b0, '0},              // Fibonacci, most steps
		'{31'd1134903170, 31'd1836311903, 1'b0, '0},
		'{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0},
		'{31'd240, 31'd46, 1'b0, '0},
		'{31'd46, 31'd240, 1'b0, '0},
		'{OPND_MAX, 31'h4000_0000, 1'b0, '0},
		'{31'h7FFF_FFFE, OPND_MAX, 1'b0, '0}
	};

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [OW-1:0] a_value;
	logic [OW-1:0] b_value;
	logic          out_valid;
	logic          out_ready;
	logic [OW-1:0] gcd_value;
	logic signed [CW-1:0] coeff_a;
	logic signed [CW-1:0] coeff_b;

	bezout_t expected_q [$];
	int      errors       = 0;
	int      pairs_sent   = 0;
	int      results_seen = 0;
	int      snd_idle_pct = 13;
	int      rcv_idle_pct = 80;

	extended_gcd_bezout_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_value   (a_value),
		.b_value   (b_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gcd_value (gcd_value),
		.coeff_a   (coeff_a),
		.coeff_b   (coeff_b)
	);

	always #5 clk = ~clk;

	// Euclid on 64-bit wrapping words, larger operand as dividend; coefficients
	// swapped back when a < b.
	function automatic bezout_t bezout_of(input logic [OW-1:0] a, input logic [OW-1:0] b);
		bit [63:0] r_old, r_new, q, r, x_old, x_new, y_old, y_new, nxt;
		bit        swapped;
		bezout_t   res;
		swapped = (a < b);
		r_old = swapped ? 64'(b) : 64'(a);
		r_new = swapped ? 64'(a) : 64'(b);
		x_old = 64'd1;
		x_new = 64'd0;
		y_old = 64'd0;
		y_new = 64'd1;
		while (r_new != 64'd0) begin
			q = r_old / r_new;
			r = r_old % r_new;
			nxt = x_old - q * x_new;
			x_old = x_new;
			x_new = nxt;
			nxt = y_old - q * y_new;
			y_old = y_new;
			y_new = nxt;
			r_old = r_new;
			r_new = r;
		end
		res.gcd = r_old[OW-1:0];
		res.ca  = swapped ? y_old[CW-1:0] : x_old[CW-1:0];
		res.cb  = swapped ? x_old[CW-1:0] : y_old[CW-1:0];
		return res;
	endfunction

	task automatic report(input string what, input logic [CW-1:0] got, input logic [CW-1:0] want);
		$display("ERROR result %0d %s: got %h want %h", results_seen, what, got, want);
		errors++;
	endtask

	// One input beat; the expectation is queued at the accepting edge.
	task automatic send_pair(input logic [OW-1:0] a, input logic [OW-1:0] b,
			input bezout_t want);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_value  <= a;
		b_value  <= b;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(want);
		pairs_sent++;
	endtask

	task automatic drain;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Result side: sample pre-edge values, then pick next ready.
	always @(posedge clk) begin
		bezout_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report("unexpected beat", {1'b0, gcd_value}, '0);
				end else begin
					want = expected_q.pop_front();
					if (gcd_value !== want.gcd)
						report("gcd_value", {1'b0, gcd_value}, {1'b0, want.gcd});
					if (coeff_a !== want.ca)
						report("coeff_a", coeff_a, want.ca);
					if (coeff_b !== want.cb)
						report("coeff_b", coeff_b, want.cb);
				end
			end
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end else begin
			out_ready <= 1'b0;
		end
	end

	initial begin
		#(20_000_000);
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("extended_gcd_bezout_core: mismatch");
		$finish;
	end

	initial begin
		logic [OW-1:0]   a_nxt, b_nxt, tmp;
		longint unsigned fac, lim, fa, fb, ft;
		int              k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		a_value   = '0;
		b_value   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_pair(DIRECTED[i].a, DIRECTED[i].b,
				DIRECTED[i].typed ? DIRECTED[i].res
					: bezout_of(DIRECTED[i].a, DIRECTED[i].b));

		for (int phase = 0; phase < 3; phase++) begin
			// sender holds off until the block and the result side are empty
			in_valid <= 1'b0;
			drain();
			snd_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
			rcv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				case ($urandom_range(9)) inside
					0, 1, 2: begin
						a_nxt = OW'($urandom_range(32'h7FFF_FFFF, 1));
						b_nxt = OW'($urandom_range(32'h7FFF_FFFF, 1));
					end
					3: begin // shared factor
						fac = $urandom_range(65536, 1);
						lim = 64'(OPND_MAX) / fac;
						a_nxt = OW'(fac * $urandom_range(32'(lim), 1));
						b_nxt = OW'(fac * $urandom_range(32'(lim), 1));
					end
					4: begin // adjacent Fibonacci numbers, long quotient chains
						fa = 1;
						fb = 1;
						k = $urandom_range(44, 1);
						repeat (k) begin
							ft = fa + fb;
							fa = fb;
							fb = ft;
						end
						a_nxt = OW'(fb);
						b_nxt = OW'(fa);
					end
					5: begin
						a_nxt = OW'($urandom_range(32'h7FFF_FFFF, 1));
						b_nxt = a_nxt;
					end
					6: begin
						a_nxt = OW'($urandom_range(255, 1));
						b_nxt = OW'($urandom_range(255, 1));
					end
					7: begin // one divides the other
						a_nxt = OW'($urandom_range(65535, 1));
						lim = 64'(OPND_MAX) / 64'(a_nxt);
						b_nxt = OW'(64'(a_nxt) * $urandom_range(32'(lim), 1));
					end
					8: begin
						a_nxt = OW'(1) << $urandom_range(OW - 1);
						b_nxt = OW'($urandom_range(32'h7FFF_FFFF, 1));
					end
					default: begin // close large values
						a_nxt = OW'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
						b_nxt = a_nxt - OW'($urandom_range(1000, 1));
					end
				endcase
				if ($urandom_range(1)) begin
					tmp   = a_nxt;
					a_nxt = b_nxt;
					b_nxt = tmp;
				end
				send_pair(a_nxt, b_nxt, bezout_of(a_nxt, b_nxt));
			end
		end
		in_valid <= 1'b0;
		drain();
		repeat (100) @(posedge clk);

		$display("%0d operand pairs sent (zero, equal, extreme, Fibonacci, shared-factor mixes)",
			pairs_sent);
		$display("%0d results compared under three stall profiles, %0d errors",
			results_seen, errors);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("extended_gcd_bezout_core: match");
		end else begin
			$display("extended_gcd_bezout_core: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/egb_pkg.sv
rtl/egb_datapath.sv
rtl/egb_ctrl.sv
rtl/extended_gcd_bezout_core.sv
rtl/egb_checker.sv
tb/extended_gcd_bezout_core_test.sv
